FILE: rtl/core/hfhw_pkg.sv
// Package for the HTTP/3 frame header walker.
// Holds the word types, sizing constants and the push bundle shared by all modules.
// No dependencies.
`default_nettype none

package hfhw_pkg;

    localparam int MAX_FRAMES       = 256;
    localparam int MAX_BUFFER_BYTES = 65535;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int VAL_W   = 62;
    localparam int FOUND_W = 9;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [5:0] FIRST_BYTE_MASK = 6'h3f;

    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  buffer_length;
        logic              last_byte;
    } src_word_t;

    typedef struct packed {
        logic               result_kind;
        logic [VAL_W-1:0]   frame_type;
        logic [VAL_W-1:0]   frame_length;
        logic [LEN_W-1:0]   payload_start;
        logic [FOUND_W-1:0] frames_found;
        logic               last_of_run;
    } res_word_t;

    typedef struct packed {
        logic [1:0] count;
        res_word_t  first;
        res_word_t  second;
    } push_t;

    function automatic logic [FOUND_W-1:0] found_of(input logic [CNT_W-1:0] cnt);
        return FOUND_W'(cnt);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hfhw_parser.sv
// Varint and frame header parser state for the HTTP/3 frame header walker.
// Consumes one registered byte per step and produces up to two result words.
// Depends on hfhw_pkg.
`default_nettype none

module hfhw_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire hfhw_pkg::src_word_t word,
    output hfhw_pkg::push_t         push
);
    import hfhw_pkg::*;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_SKIP,
        PH_STOP
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [2:0]         left_reg, left_next;
    logic [VAL_W-1:0]   accum_reg, accum_next;
    logic [VAL_W-1:0]   held_reg, held_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   skip_reg, skip_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic [LEN_W-1:0]   blen;
    logic [LEN_W-1:0]   npos;
    logic [LEN_W-1:0]   room;
    logic [LEN_W-1:0]   skip_dec;
    logic [3:0]         vsize;
    logic               trunc;
    logic               overrun;
    logic               done;
    logic               take;
    logic [VAL_W-1:0]   acc_new;
    logic [2:0]         left_new;
    res_word_t          frame_res;
    res_word_t          sum_res;

    always_comb
    begin
        blen = (word.buffer_length > LEN_W'(MAX_BUFFER_BYTES)) ?
               LEN_W'(MAX_BUFFER_BYTES) : word.buffer_length;
        npos = (pos_reg != {LEN_W{1'b1}}) ? pos_reg + LEN_W'(1) : pos_reg;
        room = (blen > npos) ? blen - npos : '0;
        skip_dec = (skip_reg != '0) ? skip_reg - LEN_W'(1) : '0;
        vsize = 4'(1) << word.data_byte[7:6];
        trunc = ({1'b0, pos_reg} + (LEN_W+1)'(vsize)) > {1'b0, blen};

        phase_next = phase_reg;
        left_next  = left_reg;
        accum_next = accum_reg;
        held_next  = held_reg;
        skip_next  = skip_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        done       = 1'b0;
        take       = 1'b0;
        overrun    = 1'b0;
        acc_new    = accum_reg;
        left_new   = left_reg;
        frame_res  = '0;
        sum_res    = '0;
        push       = '0;

        if (step)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE, PH_LEN:
                begin
                    if (left_reg == '0)
                    begin
                        if (phase_reg == PH_TYPE && count_reg >= CNT_W'(MAX_FRAMES))
                        begin
                            phase_next = PH_STOP;
                        end
                        else if (trunc)
                        begin
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            acc_new  = VAL_W'(word.data_byte[5:0] & FIRST_BYTE_MASK);
                            left_new = 3'(vsize - 4'(1));
                            take     = 1'b1;
                        end
                    end
                    else
                    begin
                        acc_new  = {accum_reg[VAL_W-BYTE_W-1:0], word.data_byte};
                        left_new = left_reg - 3'(1);
                        take     = 1'b1;
                    end
                    if (take)
                    begin
                        accum_next = acc_new;
                        left_next  = left_new;
                        done       = (left_new == '0);
                    end
                    if (done)
                    begin
                        accum_next = '0;
                        if (phase_reg == PH_TYPE)
                        begin
                            held_next  = acc_new;
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            overrun = (acc_new[VAL_W-1:LEN_W] != '0) ||
                                      (acc_new[LEN_W-1:0] > room);
                            if (overrun)
                            begin
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                count_next               = count_reg + CNT_W'(1);
                                frame_res.result_kind    = KIND_FRAME;
                                frame_res.frame_type     = held_reg;
                                frame_res.frame_length   = acc_new;
                                frame_res.payload_start  = npos;
                                frame_res.frames_found   = found_of(count_reg + CNT_W'(1));
                                frame_res.last_of_run    = ~word.last_byte;
                                skip_next                = acc_new[LEN_W-1:0];
                                phase_next = (acc_new == '0) ? PH_TYPE : PH_SKIP;
                                push.count = 2'd1;
                                push.first = frame_res;
                            end
                        end
                    end
                end
                PH_STOP:
                begin
                    phase_next = PH_STOP;
                end
                default:
                begin
                    phase_next = PH_STOP;
                end
            endcase

            pos_next = npos;

            if (word.last_byte)
            begin
                sum_res.result_kind  = KIND_SUMMARY;
                sum_res.frames_found = found_of(count_next);
                sum_res.last_of_run  = 1'b1;
                if (push.count == 2'd1)
                begin
                    push.second = sum_res;
                    push.count  = 2'd2;
                end
                else
                begin
                    push.first = sum_res;
                    push.count = 2'd1;
                end
                phase_next = PH_TYPE;
                left_next  = '0;
                accum_next = '0;
                held_next  = '0;
                pos_next   = '0;
                skip_next  = '0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            left_reg  <= '0;
            accum_reg <= '0;
            held_reg  <= '0;
            pos_reg   <= '0;
            skip_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            accum_reg <= accum_next;
            held_reg  <= held_next;
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hfhw_result_fifo.sv
// Result queue for the HTTP/3 frame header walker.
// Takes up to two result words per cycle and delivers one per cycle while res_ready is high.
// Depends on hfhw_pkg.
`default_nettype none

module hfhw_result_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hfhw_pkg::push_t     push,
    output logic                    room,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output hfhw_pkg::res_word_t     res_data
);
    import hfhw_pkg::*;

    res_word_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 pop;

    assign pop       = res_valid && res_ready;
    assign res_valid = (count_reg != '0);
    assign res_data  = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + FIFO_AW'(1)] <= push.second;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/http3_frame_header_walker_unit.sv
// Top level of the HTTP/3 frame header walker.
// Input register, parser step and result queue. Depends on hfhw_pkg,
// hfhw_parser and hfhw_result_fifo.
//
//  Channel  Handshake             Word        Contents
//  src      src_valid/src_ready   src_data    data_byte, buffer_length, last_byte
//  res      res_valid/res_ready   res_data    frame header or end-of-buffer summary
//
// One byte is accepted per cycle while the queue has room; its results come from the
// input register, one result word per cycle from a four-entry queue while res_ready is high.
// A byte that ends the buffer right after a frame length yields two words.
// The input register advances only while the queue has room for two words.
// Reset is asynchronous and returns the parser to the start of a buffer.
`default_nettype none

module http3_frame_header_walker_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                src_valid,
    output logic                     src_ready,
    input  wire hfhw_pkg::src_word_t  src_data,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output hfhw_pkg::res_word_t      res_data
);
    import hfhw_pkg::*;

    src_word_t  src_reg;
    logic       src_valid_reg, src_valid_next;
    logic       room;
    logic       advance;
    push_t      push;

    assign advance        = src_valid_reg && room;
    assign src_ready      = !src_valid_reg || advance;
    assign src_valid_next = src_valid ? 1'b1 : (advance ? 1'b0 : src_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            src_valid_reg <= src_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
        begin
            src_reg <= src_data;
        end
    end

    hfhw_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .word  (src_reg),
        .push  (push)
    );

    hfhw_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/hfhw_checker.sv
// Port-level checks for the HTTP/3 frame header walker, with the bind to the top level.
// Depends on hfhw_pkg and http3_frame_header_walker_unit.
`default_nettype none

module hfhw_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                src_valid,
    input  wire logic                src_ready,
    input  wire hfhw_pkg::src_word_t  src_data,
    input  wire logic                res_valid,
    input  wire logic                res_ready,
    input  wire hfhw_pkg::res_word_t  res_data
);
    import hfhw_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result word changed while stalled");

    a_summary_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.result_kind == KIND_SUMMARY |-> res_data.last_of_run)
        else $error("summary word not marked as end of run");

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.result_kind == KIND_SUMMARY |->
        res_data.frame_type == '0 && res_data.frame_length == '0 &&
        res_data.payload_start == '0)
        else $error("summary word carries frame fields");

    a_frame_offset: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.result_kind == KIND_FRAME |-> res_data.payload_start != '0)
        else $error("frame word with payload start zero");

    a_no_early_result: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result word right after reset");

endmodule

bind http3_frame_header_walker_unit hfhw_checker u_hfhw_checker (.*);

`default_nettype wire

FILE: tb/sv/http3_frame_header_walker_unit_test.sv
// Testbench for http3_frame_header_walker_unit: drives byte words from a queue and checks
// every result word against a cycle-free model of the frame header walk.
// Depends on hfhw_pkg and the walker RTL.
`timescale 1ns / 1ps

module http3_frame_header_walker_unit_test;

    import hfhw_pkg::*;

    typedef enum logic [1:0] {
        WALK_TYPE = 2'd0,
        WALK_LEN  = 2'd1,
        WALK_SKIP = 2'd2,
        WALK_STOP = 2'd3
    } walk_phase_e;

    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BYTES  = 550;
    localparam int MAX_REPORTS   = 100;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_ready;
    src_word_t src_data = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_word_t res_data;

    src_word_t   byte_queue[$];
    res_word_t   pending_results[$];
    logic [7:0]  frame_bytes[$];

    walk_phase_e walk_phase = WALK_TYPE;
    int          varint_owed = 0;
    logic [61:0] varint_value = '0;
    logic [61:0] type_held = '0;
    int          walk_pos = 0;
    int          payload_left = 0;
    int          frames_seen = 0;

    int          bytes_taken = 0;
    int          mismatches = 0;
    logic        steady;

    http3_frame_header_walker_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #2 clk = ~clk;

    assign steady = (bytes_taken >= 300) && (bytes_taken < 700);

    function automatic void clear_walk();
        walk_phase   = WALK_TYPE;
        varint_owed  = 0;
        varint_value = '0;
        type_held    = '0;
        walk_pos     = 0;
        payload_left = 0;
        frames_seen  = 0;
    endfunction

    function automatic void walk_byte(input src_word_t w);
        int        eff_len;
        int        next_pos;
        int        vsize;
        int        room;
        int        produced;
        logic      finished;
        res_word_t r;
        eff_len  = (int'(w.buffer_length) > MAX_BUFFER_BYTES) ? MAX_BUFFER_BYTES
                                                              : int'(w.buffer_length);
        next_pos = (walk_pos < 65535) ? walk_pos + 1 : 65535;
        finished = 1'b0;
        produced = 0;
        case (walk_phase)
            WALK_SKIP:
            begin
                if (payload_left > 0)
                    payload_left--;
                if (payload_left == 0)
                    walk_phase = WALK_TYPE;
            end
            WALK_TYPE, WALK_LEN:
            begin
                if (varint_owed == 0)
                begin
                    vsize = 1 << w.data_byte[7:6];
                    if (walk_phase == WALK_TYPE && frames_seen >= MAX_FRAMES)
                        walk_phase = WALK_STOP;
                    else if (walk_pos + vsize > eff_len)
                        walk_phase = WALK_STOP;
                    else
                    begin
                        varint_value = 62'(w.data_byte[5:0]);
                        varint_owed  = vsize - 1;
                        finished     = (varint_owed == 0);
                    end
                end
                else
                begin
                    varint_value = {varint_value[53:0], w.data_byte};
                    varint_owed--;
                    finished = (varint_owed == 0);
                end
                if (finished)
                begin
                    if (walk_phase == WALK_TYPE)
                    begin
                        type_held  = varint_value;
                        walk_phase = WALK_LEN;
                    end
                    else
                    begin
                        room = (eff_len > next_pos) ? eff_len - next_pos : 0;
                        if (varint_value > 62'(room))
                            walk_phase = WALK_STOP;
                        else
                        begin
                            frames_seen++;
                            r.result_kind    = KIND_FRAME;
                            r.frame_type     = type_held;
                            r.frame_length   = varint_value;
                            r.payload_start  = 16'(next_pos);
                            r.frames_found   = FOUND_W'(frames_seen);
                            r.last_of_run    = 1'b0;
                            pending_results.insert(pending_results.size(), r);
                            produced++;
                            payload_left = int'(varint_value[15:0]);
                            walk_phase   = (varint_value == '0) ? WALK_TYPE : WALK_SKIP;
                        end
                    end
                    varint_value = '0;
                end
            end
            default:
            begin
            end
        endcase
        walk_pos = next_pos;
        if (w.last_byte)
        begin
            r.result_kind    = KIND_SUMMARY;
            r.frame_type     = '0;
            r.frame_length   = '0;
            r.payload_start  = '0;
            r.frames_found   = FOUND_W'(frames_seen);
            r.last_of_run    = 1'b0;
            pending_results.insert(pending_results.size(), r);
            produced++;
            clear_walk();
        end
        if (produced > 0)
            pending_results[pending_results.size() - 1].last_of_run = 1'b1;
    endfunction

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
        end
        else
        begin
            if (src_valid && src_ready)
            begin
                walk_byte(src_data);
                bytes_taken <= bytes_taken + 1;
            end
            if (!src_valid || src_ready)
            begin
                if (byte_queue.size() > 0 && (steady || $urandom_range(99) >= 14))
                begin
                    src_data  <= byte_queue[0];
                    byte_queue.delete(0);
                    src_valid <= 1'b1;
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        res_word_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: unexpected word, expected none, got 0x%0h",
                                 $time, res_data);
                    mismatches++;
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    check_field("result_kind", 64'(want.result_kind), 64'(res_data.result_kind));
                    check_field("frame_type", 64'(want.frame_type), 64'(res_data.frame_type));
                    check_field("frame_length", 64'(want.frame_length),
                                64'(res_data.frame_length));
                    check_field("payload_start", 64'(want.payload_start),
                                64'(res_data.payload_start));
                    check_field("frames_found", 64'(want.frames_found),
                                64'(res_data.frames_found));
                    check_field("last_of_run", 64'(want.last_of_run), 64'(res_data.last_of_run));
                end
            end
            res_ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    task automatic append_varint(input logic [61:0] value, input int code);
        int         nb;
        logic [7:0] bt;
        nb = 1 << code;
        for (int i = nb - 1; i >= 0; i--)
        begin
            bt = 8'(value >> (8 * i));
            if (i == nb - 1)
                bt[7:6] = 2'(code);
            frame_bytes.insert(frame_bytes.size(), bt);
        end
    endtask

    task automatic send_buffer(input int blen, input bit jitter);
        int        n;
        int        bl;
        src_word_t w;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            bl = blen;
            if (jitter)
                bl = blen + int'($urandom_range(0, 4)) - 2;
            if (bl < 1)
                bl = 1;
            if (bl > 65535)
                bl = 65535;
            w.data_byte     = frame_bytes[i];
            w.buffer_length = 16'(bl);
            w.last_byte     = (i == n - 1);
            byte_queue.insert(byte_queue.size(), w);
        end
        frame_bytes.delete();
    endtask

    function automatic int pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        else if (r < 75)
            return 1;
        else if (r < 90)
            return 2;
        return 3;
    endfunction

    task automatic random_buffer();
        int          nframes;
        int          size;
        int          r;
        logic [61:0] len_value;
        nframes = $urandom_range(0, 5);
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 20))
                frame_bytes.insert(frame_bytes.size(), 8'($urandom));
        end
        else
        begin
            repeat (nframes)
            begin
                append_varint(62'({$urandom, $urandom}), pick_code());
                if ($urandom_range(9) == 0)
                    len_value = 62'({$urandom, $urandom});
                else
                    len_value = 62'($urandom_range(0, 12));
                append_varint(len_value, pick_code());
                if (len_value <= 62'd12)
                    repeat (int'(len_value))
                        frame_bytes.insert(frame_bytes.size(), 8'($urandom));
            end
            if ($urandom_range(7) == 0 || frame_bytes.size() == 0)
                repeat ($urandom_range(1, 3))
                    frame_bytes.insert(frame_bytes.size(), 8'($urandom));
        end
        size = frame_bytes.size();
        r = $urandom_range(99);
        if (r < 70)
            send_buffer(size, 1'b0);
        else if (r < 80)
            send_buffer(int'($urandom_range(1, size)), 1'b0);
        else if (r < 90)
            send_buffer(int'($urandom_range(size, 65535)), 1'b0);
        else
            send_buffer(size, 1'b1);
    endtask

    initial
    begin
        int target;

        // A single zero type byte ends the buffer with no frame.
        frame_bytes.insert(frame_bytes.size(), 8'h00);
        send_buffer(1, 1'b0);
        // The frame length and the end of the buffer fall on the same byte.
        frame_bytes = '{8'h3f, 8'h00};
        send_buffer(2, 1'b0);
        // An eight-byte varint that runs past the end stops the walk.
        frame_bytes = '{8'hc0, 8'hff, 8'h80, 8'h7f};
        send_buffer(4, 1'b0);
        // The frame length overruns the buffer.
        frame_bytes = '{8'h01, 8'h05, 8'haa, 8'h55};
        send_buffer(4, 1'b0);
        // The buffer ends in the middle of a payload.
        frame_bytes = '{8'h01, 8'h04, 8'hff, 8'h00};
        send_buffer(6, 1'b0);
        // Bytes past the stated length are ignored.
        frame_bytes = '{8'h00, 8'h00, 8'hff, 8'hff};
        send_buffer(2, 1'b0);
        // Largest value of the type field and a length that fills the rest of the buffer.
        frame_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h40, 8'h01,
                        8'h00};
        send_buffer(11, 1'b0);

        // More frames than the limit allows.
        repeat (MAX_FRAMES + 2)
        begin
            frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 63)));
            frame_bytes.insert(frame_bytes.size(), 8'h00);
        end
        send_buffer(2 * (MAX_FRAMES + 2), 1'b0);

        target = byte_queue.size() + RANDOM_BYTES;
        while (byte_queue.size() < target)
            random_buffer();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || src_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

endmodule
